// ===== src/periodic_k_nearest_neighbors_top_defines.svh =====
// Assertion macros for the periodic nearest-neighbor search block.
// Used by the top level only; relies on clk and arst_n in the including scope.
`ifndef PERIODIC_K_NEAREST_NEIGHBORS_TOP_DEFINES_SVH
`define PERIODIC_K_NEAREST_NEIGHBORS_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PKNN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PKNN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pknn_pkg.sv =====
// Shared types, constants and arithmetic helpers for the periodic nearest-neighbor search.
// No dependencies.
package pknn_pkg;

	localparam int MAX_ATOMS_DEF = 1024;
	localparam int NEIGHBORS_DEF = 12;
	localparam int SQRT_STEPS    = 32;

	localparam int REG_IDX_W = 3;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_ATOM_COUNT = 3'd0,
		REG_BOX_HALF_X = 3'd1,
		REG_BOX_HALF_Y = 3'd2,
		REG_BOX_HALF_Z = 3'd3,
		REG_CUTOFF     = 3'd4
	} reg_idx_t;

	localparam logic [10:0] ATOM_COUNT_RST = 11'd0;
	localparam logic [29:0] BOX_HALF_RST   = 30'd655360;
	localparam logic [31:0] CUTOFF_RST     = 32'd6488064;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QREAD,
		ST_QCAP,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// Payload of one square-root cell.
	typedef struct packed {
		logic        vld;
		logic [63:0] rem;
		logic [63:0] root;
		logic [9:0]  idx;
	} sq_t;

	// Control of the sorted neighbor list.
	typedef struct packed {
		logic init;
		logic ins;
		logic shift;
	} lst_ctl_t;

	// One minimum-image correction of a signed axis difference.
	function automatic logic signed [34:0] axis_fold(input logic signed [32:0] d,
		input logic [29:0] half);
		logic signed [34:0] dd;
		logic signed [34:0] ll;
		logic signed [34:0] r;
		dd = 35'(d);
		ll = $signed({5'b0, half});
		if (dd > ll) begin
			r = dd - (ll <<< 1);
		end else if (dd < -ll) begin
			r = dd + (ll <<< 1);
		end else begin
			r = dd;
		end
		return r;
	endfunction

	// Magnitude, saturated at 2^31.
	function automatic logic [31:0] abs_sat(input logic signed [34:0] v);
		logic [34:0] m;
		m = v[34] ? 35'(-v) : 35'(v);
		if (m > 35'h0_8000_0000) begin
			m = 35'h0_8000_0000;
		end
		return m[31:0];
	endfunction

endpackage

// ===== src/periodic_k_nearest_neighbors_top.sv =====
// Periodic k-nearest-neighbor search over stored atom positions.
// After a query transfer the states QREAD and QCAP fetch the queried atom, one memory read
// per atom follows for the n searched atoms, then the 38-stage distance and square-root
// pipeline drains into the sorted list. NEIGHBORS results follow; the next command is taken
// once the last of them has been transferred. arst_n clears control state and sets
// registers to their defaults; positions are not cleared.
module periodic_k_nearest_neighbors_top import pknn_pkg::*; #(
	parameter int MAX_ATOMS = MAX_ATOMS_DEF,
	parameter int NEIGHBORS = NEIGHBORS_DEF,
	localparam int SLOT_W = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [31:0]          wr_data,
	// Command channel.
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [9:0]           atom_index,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	// Result channel.
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SLOT_W-1:0]    slot,
	output logic [9:0]           neighbor_index,
	output logic [31:0]          distance,
	output logic                 last
);

`include "periodic_k_nearest_neighbors_top_defines.svh"

	localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int CW = $clog2(MAX_ATOMS + 1);
	// Cycles from the last issued atom until its distance has reached the list.
	localparam int DRAIN_CYCLES = SQRT_STEPS + 8;
	localparam int DW = $clog2(DRAIN_CYCLES + 1);

	// Configuration registers.
	logic [10:0] atom_count_q;
	logic [29:0] half_x_q, half_y_q, half_z_q;
	logic [31:0] cutoff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_count_q <= ATOM_COUNT_RST;
			half_x_q     <= BOX_HALF_RST;
			half_y_q     <= BOX_HALF_RST;
			half_z_q     <= BOX_HALF_RST;
			cutoff_q     <= CUTOFF_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_ATOM_COUNT: atom_count_q <= wr_data[10:0];
				REG_BOX_HALF_X: half_x_q     <= wr_data[29:0];
				REG_BOX_HALF_Y: half_y_q     <= wr_data[29:0];
				REG_BOX_HALF_Z: half_z_q     <= wr_data[29:0];
				REG_CUTOFF:     cutoff_q     <= wr_data;
				default: ;
			endcase
		end
	end

	// Sequencer state.
	state_t         state_q, state_d;
	logic [CW-1:0]  j_q;
	logic [CW-1:0]  n_q;
	logic [9:0]     qidx_q;
	logic           qvalid_q;
	logic [DW-1:0]  drain_q;
	logic [SLOT_W-1:0] emit_q;

	logic in_xfer, out_xfer, load_xfer, query_xfer;
	logic idx_in_range;
	logic issue;
	logic rd_q_sel;
	lst_ctl_t lst_ctl;
	logic [CW-1:0] n_clip;

	assign in_xfer      = in_valid && !in_stall;
	assign out_xfer     = out_valid && !out_stall;
	assign idx_in_range = 32'(atom_index) < MAX_ATOMS;
	assign load_xfer    = in_xfer && (command == CMD_LOAD);
	assign query_xfer   = in_xfer && (command == CMD_QUERY);
	assign n_clip       = (32'(atom_count_q) > MAX_ATOMS) ? CW'(MAX_ATOMS) : CW'(atom_count_q);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (query_xfer) state_d = ST_QREAD;
			ST_QREAD: state_d = ST_QCAP;
			ST_QCAP:  state_d = (n_q == '0) ? ST_DRAIN : ST_RUN;
			ST_RUN:   if (j_q == n_q - CW'(1)) state_d = ST_DRAIN;
			ST_DRAIN: if (drain_q == DW'(DRAIN_CYCLES - 1)) state_d = ST_EMIT;
			ST_EMIT:  if (out_xfer && emit_q == SLOT_W'(NEIGHBORS - 1)) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Square root: a chain of cells, one result bit each, most significant first.
	sq_t sq_chain [SQRT_STEPS+1];

	// Output decode of the sequencer. A distance leaving the square root is inserted.
	always_comb begin
		in_stall      = 1'b1;
		out_valid     = 1'b0;
		issue         = 1'b0;
		rd_q_sel      = 1'b0;
		lst_ctl.init  = 1'b0;
		lst_ctl.shift = 1'b0;
		lst_ctl.ins   = sq_chain[SQRT_STEPS].vld;
		case (state_q)
			ST_IDLE: begin
				in_stall     = 1'b0;
				lst_ctl.init = query_xfer;
			end
			ST_QREAD: rd_q_sel = 1'b1;
			ST_RUN:   issue = 1'b1;
			ST_EMIT: begin
				out_valid     = 1'b1;
				lst_ctl.shift = out_xfer;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			n_q     <= '0;
			qidx_q  <= '0;
			qvalid_q <= 1'b0;
			drain_q <= '0;
			emit_q  <= '0;
		end else begin
			state_q <= state_d;
			if (query_xfer) begin
				qidx_q   <= atom_index;
				qvalid_q <= idx_in_range;
				n_q      <= n_clip;
				j_q      <= '0;
				drain_q  <= '0;
				emit_q   <= '0;
			end
			if (issue) begin
				j_q <= j_q + CW'(1);
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + DW'(1);
			end
			if (out_xfer) begin
				emit_q <= emit_q + SLOT_W'(1);
			end
		end
	end

	// Position memory: loads write, the sequencer reads the queried atom and then every atom.
	logic [31:0]   rd_x, rd_y, rd_z;
	logic [AW-1:0] raddr;

	assign raddr = rd_q_sel ? AW'(qidx_q) : j_q[AW-1:0];

	pknn_store #(.MAX_ATOMS(MAX_ATOMS)) u_store (
		.clk   (clk),
		.we    (load_xfer && idx_in_range),
		.waddr (AW'(atom_index)),
		.wx    (pos_x),
		.wy    (pos_y),
		.wz    (pos_z),
		.raddr (raddr),
		.rx    (rd_x),
		.ry    (rd_y),
		.rz    (rd_z)
	);

	// Position of the queried atom; an out-of-range index reads as the origin.
	logic [31:0] q_x_q, q_y_q, q_z_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_QCAP) begin
			q_x_q <= qvalid_q ? rd_x : '0;
			q_y_q <= qvalid_q ? rd_y : '0;
			q_z_q <= qvalid_q ? rd_z : '0;
		end
	end

	// Distance pipeline. The queried atom itself is never marked valid.
	logic       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [9:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;
	logic signed [32:0] dx_s2, dy_s2, dz_s2;
	logic signed [34:0] fx_s3, fy_s3, fz_s3;
	logic [31:0] mx_s4, my_s4, mz_s4;
	logic [63:0] px_s5, py_s5, pz_s5;
	logic [63:0] sum_s6;
	logic skip;

	assign skip = qvalid_q && (32'(j_q) == 32'(qidx_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= issue && !skip;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= j_q[9:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		idx_s5 <= idx_s4;
		idx_s6 <= idx_s5;
		dx_s2  <= $signed({rd_x[31], rd_x}) - $signed({q_x_q[31], q_x_q});
		dy_s2  <= $signed({rd_y[31], rd_y}) - $signed({q_y_q[31], q_y_q});
		dz_s2  <= $signed({rd_z[31], rd_z}) - $signed({q_z_q[31], q_z_q});
		fx_s3  <= axis_fold(dx_s2, half_x_q);
		fy_s3  <= axis_fold(dy_s2, half_y_q);
		fz_s3  <= axis_fold(dz_s2, half_z_q);
		mx_s4  <= abs_sat(fx_s3);
		my_s4  <= abs_sat(fy_s3);
		mz_s4  <= abs_sat(fz_s3);
		px_s5  <= 64'(mx_s4) * 64'(mx_s4);
		py_s5  <= 64'(my_s4) * 64'(my_s4);
		pz_s5  <= 64'(mz_s4) * 64'(mz_s4);
		sum_s6 <= px_s5 + py_s5 + pz_s5;
	end

	assign sq_chain[0] = '{vld: vld_s6, rem: sum_s6, root: 64'd0, idx: idx_s6};

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		pknn_sqrt_cell #(.STEP(SQRT_STEPS - 1 - i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (sq_chain[i]),
			.dout   (sq_chain[i+1])
		);
	end

	// Sorted list: slot 0 holds the nearest atom. Each cell looks only at the candidate and its neighbor cells.
	logic [31:0] cand_dist;
	logic [31:0] l_dist [NEIGHBORS];
	logic [9:0]  l_idx  [NEIGHBORS];
	logic        l_lt   [NEIGHBORS];

	assign cand_dist = sq_chain[SQRT_STEPS].root[31:0];

	for (genvar k = 0; k < NEIGHBORS; k++) begin : g_list
		logic [31:0] p_dist, n_dist;
		logic [9:0]  p_idx, n_idx;
		logic        p_lt;
		if (k == 0) begin : g_head
			assign p_dist = '0;
			assign p_idx  = '0;
			assign p_lt   = 1'b0;
		end else begin : g_body
			assign p_dist = l_dist[k-1];
			assign p_idx  = l_idx[k-1];
			assign p_lt   = l_lt[k-1];
		end
		if (k == NEIGHBORS - 1) begin : g_tail
			assign n_dist = cutoff_q;
			assign n_idx  = '0;
		end else begin : g_next
			assign n_dist = l_dist[k+1];
			assign n_idx  = l_idx[k+1];
		end
		pknn_list_cell u_cell (
			.clk       (clk),
			.ctl       (lst_ctl),
			.cutoff    (cutoff_q),
			.cand_dist (cand_dist),
			.cand_idx  (sq_chain[SQRT_STEPS].idx),
			.prev_dist (p_dist),
			.prev_idx  (p_idx),
			.prev_lt   (p_lt),
			.next_dist (n_dist),
			.next_idx  (n_idx),
			.slot_dist (l_dist[k]),
			.idx       (l_idx[k]),
			.lt        (l_lt[k])
		);
	end

	// Results leave from the head of the list, which shifts forward on each transfer.
	assign slot           = emit_q;
	assign neighbor_index = l_idx[0];
	assign distance       = l_dist[0];
	assign last           = (emit_q == SLOT_W'(NEIGHBORS - 1));

	// No command is taken while results are offered.
	`PKNN_ASSERT_NOW(a_no_input_while_emit, out_valid, in_stall, "input taken during emit")
	// The final result of a query closes the result stream.
	`PKNN_ASSERT_NEXT(a_last_ends_query, out_valid && !out_stall && last, !out_valid,
		"results continue after last")
	// Slots advance by one with every non-final transfer.
	`PKNN_ASSERT_NEXT(a_slot_steps, out_valid && !out_stall && !last,
		out_valid && (slot == $past(slot) + SLOT_W'(1)), "slot sequence broken")

endmodule

// ===== src/pknn_store.sv =====
// Position memory of the periodic nearest-neighbor search: three single-port-write arrays.
// Depends on pknn_pkg.
module pknn_store import pknn_pkg::*; #(
	parameter int MAX_ATOMS = MAX_ATOMS_DEF,
	localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wx,
	input  logic [31:0]   wy,
	input  logic [31:0]   wz,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rx,
	output logic [31:0]   ry,
	output logic [31:0]   rz
);

	logic [31:0] mem_x [MAX_ATOMS];
	logic [31:0] mem_y [MAX_ATOMS];
	logic [31:0] mem_z [MAX_ATOMS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_x[waddr] <= wx;
			mem_y[waddr] <= wy;
			mem_z[waddr] <= wz;
		end
		rx <= mem_x[raddr];
		ry <= mem_y[raddr];
		rz <= mem_z[raddr];
	end

endmodule

// ===== src/pknn_sqrt_cell.sv =====
// One cell of the pipelined integer square root: settles one result bit per cycle.
// Depends on pknn_pkg.
module pknn_sqrt_cell import pknn_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  sq_t  din,
	output sq_t  dout
);

	localparam logic [63:0] BIT = 64'd1 << (2 * STEP);

	logic        vld_q;
	logic [63:0] rem_q;
	logic [63:0] root_q;
	logic [9:0]  idx_q;
	logic [63:0] trial;

	assign trial = din.root + BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= din.idx;
		if (din.rem >= trial) begin
			rem_q  <= din.rem - trial;
			root_q <= (din.root >> 1) + BIT;
		end else begin
			rem_q  <= din.rem;
			root_q <= din.root >> 1;
		end
	end

	assign dout = '{vld: vld_q, rem: rem_q, root: root_q, idx: idx_q};

endmodule

// ===== src/pknn_list_cell.sv =====
// One slot of the sorted neighbor list; takes its value from the cutoff, the candidate or a neighbor.
// Depends on pknn_pkg.
module pknn_list_cell import pknn_pkg::*; (
	input  logic        clk,
	input  lst_ctl_t    ctl,
	input  logic [31:0] cutoff,
	input  logic [31:0] cand_dist,
	input  logic [9:0]  cand_idx,
	input  logic [31:0] prev_dist,
	input  logic [9:0]  prev_idx,
	input  logic        prev_lt,
	input  logic [31:0] next_dist,
	input  logic [9:0]  next_idx,
	output logic [31:0] slot_dist,
	output logic [9:0]  idx,
	output logic        lt
);

	logic [31:0] dist_q;
	logic [9:0]  idx_q;

	// Strict compare keeps the earlier atom ahead on equal distance.
	assign lt = cand_dist < dist_q;

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			dist_q <= cutoff;
			idx_q  <= '0;
		end else if (ctl.shift) begin
			dist_q <= next_dist;
			idx_q  <= next_idx;
		end else if (ctl.ins) begin
			if (prev_lt) begin
				dist_q <= prev_dist;
				idx_q  <= prev_idx;
			end else if (lt) begin
				dist_q <= cand_dist;
				idx_q  <= cand_idx;
			end
		end
	end

	assign slot_dist = dist_q;
	assign idx       = idx_q;

endmodule
